// ===== hdl/dcc_ser_pkg.sv =====
// Shared types and constants for the DCC packet bit serialiser.
// Holds the queued-packet record, the phase codes and the checksum helpers.
// No dependencies.
package dcc_ser_pkg;

    typedef struct packed {
        logic [7:0]      addr_high;
        logic [7:0]      addr_low;
        logic [3:0][7:0] data;
        logic [2:0]      byte_count;
        logic [7:0]      repeat_count;
    } t_packet;

    typedef logic [3:0] t_phase;

    localparam t_phase PH_PRE        = 4'd0;
    localparam t_phase PH_ADDR_START = 4'd1;
    localparam t_phase PH_ADDR       = 4'd2;
    localparam t_phase PH_LOW_START  = 4'd3;
    localparam t_phase PH_LOW        = 4'd4;
    localparam t_phase PH_DATA_START = 4'd5;
    localparam t_phase PH_DATA       = 4'd6;
    localparam t_phase PH_CRC_START  = 4'd7;
    localparam t_phase PH_CRC        = 4'd8;
    localparam t_phase PH_END        = 4'd9;

    localparam logic [4:0] PREAMBLE_RESET = 5'd14;
    localparam logic [7:0] IDLE_CHECKSUM  = 8'hFF;

    localparam t_packet IDLE_PACKET = '{
        addr_high:    8'hFF,
        addr_low:     8'h00,
        data:         '0,
        byte_count:   3'd1,
        repeat_count: 8'hFF
    };

    // Long (two-byte) address: high byte above 127 but not the broadcast 0xFF
    function automatic logic is_long(input logic [7:0] addr_high);
        is_long = addr_high[7] && (addr_high != 8'hFF);
    endfunction

    function automatic logic [7:0] checksum_of(input t_packet p);
        logic [7:0] c;
        c = p.addr_high;
        if (is_long(p.addr_high)) begin
            c = c ^ p.addr_low;
        end
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < p.byte_count) begin
                c = c ^ p.data[i];
            end
        end
        checksum_of = c;
    endfunction

endpackage

// ===== hdl/dcc_packet_bit_serializer_core.sv =====
// Top level of the DCC packet bit serialiser: packet queue, bit sequencer
// and result register. Depends on dcc_ser_pkg.
//
// Usage: each request on the input channel (i_valid / o_stall) is either an
// enqueue (i_action = 0) carrying a packet, or a tick (i_action = 1) asking
// for the next track bit. Every request yields exactly one result on the
// output channel (o_valid / i_stall): an enqueue returns o_enqueue_ok (0 if
// the queue is full), a tick returns o_line_bit and o_packet_done.
// A request is worked in the cycle it is taken and its result is registered,
// so it is visible in the next cycle; one request is accepted every cycle,
// limited only by the result register, which the receiver drains.
// When the receiver stalls, the result holds and o_stall rises only while
// that result is still waiting, so a further request is taken in the cycle
// the pending result leaves.
// Reset (synchronous, i_rst_n low) empties the queue, starts a preamble of
// the idle packet and restores 14 preamble bits. i_cfg_we writes the
// preamble length; write it only while no request is outstanding.
// The next queued packet is prefetched from the queue store into a head
// register; a write to that slot is forwarded.
module dcc_packet_bit_serializer_core
    import dcc_ser_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 8,
    parameter int MAX_DATA_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [7:0]  i_address_high,
    input  logic [7:0]  i_address_low,
    input  logic [7:0]  i_data_0,
    input  logic [7:0]  i_data_1,
    input  logic [7:0]  i_data_2,
    input  logic [7:0]  i_data_3,
    input  logic [2:0]  i_byte_count,
    input  logic signed [7:0] i_repeat_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_line_bit,
    output logic        o_packet_done,
    output logic        o_enqueue_ok,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_IDX  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);
    localparam logic [2:0]        MAX_BYTES = 3'(MAX_DATA_BYTES);

    // Queue store and its prefetched head entry
    t_packet r_queue [QUEUE_DEPTH];
    t_packet r_head_data;

    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [FILL_W-1:0] r_fill, n_fill;

    // Packet being sent
    t_packet    r_cur, n_cur;
    logic [7:0] r_cur_csum, n_cur_csum;
    logic       r_cur_idle, n_cur_idle;

    // Bit sequencer
    t_phase     r_phase, n_phase;
    logic [4:0] r_bit_cnt, n_bit_cnt;
    logic [1:0] r_byte_idx, n_byte_idx;

    logic [4:0] r_preamble;

    // Result register
    logic r_out_valid;
    logic r_line_bit, n_line_bit;
    logic r_packet_done, n_packet_done;
    logic r_enqueue_ok, n_enqueue_ok;

    logic       accept;
    logic       wr_en;
    t_packet    wr_data;
    t_packet    enq_pkt;
    t_packet    done_pkt;
    logic       keep;
    logic [2:0] enq_count;
    logic [7:0] cur_byte;
    logic [4:0] bit_inc;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    // Take a request whenever the result register is empty or being drained
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // Clamp the data byte count to one .. MAX_DATA_BYTES
    always_comb begin
        if (i_byte_count == 3'd0) begin
            enq_count = 3'd1;
        end else if (i_byte_count > MAX_BYTES) begin
            enq_count = MAX_BYTES;
        end else begin
            enq_count = i_byte_count;
        end
        enq_pkt.addr_high    = i_address_high;
        enq_pkt.addr_low     = i_address_low;
        enq_pkt.data         = {i_data_3, i_data_2, i_data_1, i_data_0};
        enq_pkt.byte_count   = enq_count;
        enq_pkt.repeat_count = i_repeat_count;
    end

    // Finished packet with a positive repeat count stepped down
    always_comb begin
        done_pkt = r_cur;
        if (!r_cur_idle && ($signed(r_cur.repeat_count) > 8'sd0)) begin
            done_pkt.repeat_count = r_cur.repeat_count - 8'd1;
        end
        keep = !r_cur_idle && (done_pkt.repeat_count != 8'd0);
    end

    always_comb begin
        case (r_phase)
            PH_ADDR: cur_byte = r_cur.addr_high;
            PH_LOW:  cur_byte = r_cur.addr_low;
            PH_DATA: cur_byte = r_cur.data[r_byte_idx];
            PH_CRC:  cur_byte = r_cur_csum;
            default: cur_byte = 8'h00;
        endcase
    end

    assign bit_inc = r_bit_cnt + 5'd1;

    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_fill        = r_fill;
        n_cur         = r_cur;
        n_cur_csum    = r_cur_csum;
        n_cur_idle    = r_cur_idle;
        n_phase       = r_phase;
        n_bit_cnt     = r_bit_cnt;
        n_byte_idx    = r_byte_idx;
        n_line_bit    = 1'b0;
        n_packet_done = 1'b0;
        n_enqueue_ok  = 1'b0;
        wr_en         = 1'b0;
        wr_data       = enq_pkt;

        if (accept && !i_action) begin
            // Enqueue: refuse when full
            if (r_fill < FULL_FILL) begin
                wr_en        = 1'b1;
                n_tail       = ptr_next(r_tail);
                n_fill       = r_fill + 1'b1;
                n_enqueue_ok = 1'b1;
            end
        end else if (accept) begin
            case (r_phase)
                PH_ADDR_START, PH_LOW_START, PH_DATA_START, PH_CRC_START: begin
                    n_line_bit = 1'b0;
                    n_phase    = r_phase + 4'd1;
                    n_bit_cnt  = '0;
                end
                PH_ADDR, PH_LOW, PH_DATA, PH_CRC: begin
                    n_line_bit = cur_byte[3'd7 - r_bit_cnt[2:0]];
                    n_bit_cnt  = bit_inc;
                    if (bit_inc >= 5'd8) begin
                        n_bit_cnt = '0;
                        case (r_phase)
                            PH_ADDR: begin
                                n_phase    = is_long(r_cur.addr_high) ? PH_LOW_START
                                                                      : PH_DATA_START;
                                n_byte_idx = '0;
                            end
                            PH_LOW: begin
                                n_phase    = PH_DATA_START;
                                n_byte_idx = '0;
                            end
                            PH_DATA: begin
                                if (({1'b0, r_byte_idx} + 3'd1) >= r_cur.byte_count) begin
                                    n_phase    = PH_CRC_START;
                                    n_byte_idx = '0;
                                end else begin
                                    n_phase    = PH_DATA_START;
                                    n_byte_idx = r_byte_idx + 2'd1;
                                end
                            end
                            default: begin
                                n_phase = PH_END;
                            end
                        endcase
                    end
                end
                PH_END: begin
                    n_line_bit    = 1'b1;
                    n_packet_done = 1'b1;
                    n_phase       = PH_PRE;
                    n_bit_cnt     = '0;
                    n_byte_idx    = '0;
                    wr_data       = done_pkt;
                    // Pop the head first, then requeue the finished packet
                    if (r_fill != '0) begin
                        n_cur  = r_head_data;
                        n_head = ptr_next(r_head);
                        if (keep) begin
                            wr_en  = 1'b1;
                            n_tail = ptr_next(r_tail);
                        end else begin
                            n_fill = r_fill - 1'b1;
                        end
                    end else if (keep) begin
                        // Empty queue: the same packet goes straight out again
                        wr_en  = 1'b1;
                        n_cur  = done_pkt;
                        n_tail = ptr_next(r_tail);
                        n_head = ptr_next(r_head);
                    end else begin
                        n_cur = IDLE_PACKET;
                    end
                    n_cur_idle = (r_fill == '0) && !keep;
                    n_cur_csum = checksum_of(n_cur);
                end
                default: begin
                    // Preamble; at least one bit even for a tiny setting
                    n_line_bit = 1'b1;
                    if (bit_inc >= r_preamble) begin
                        n_phase   = PH_ADDR_START;
                        n_bit_cnt = '0;
                    end else begin
                        n_phase   = PH_PRE;
                        n_bit_cnt = bit_inc;
                    end
                end
            endcase
        end
    end

    // Queue store: one write, one registered read at the next head
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_queue[r_tail] <= wr_data;
        end
        if (wr_en && (r_tail == n_head)) begin
            r_head_data <= wr_data;
        end else begin
            r_head_data <= r_queue[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_fill     <= '0;
            r_cur      <= IDLE_PACKET;
            r_cur_csum <= IDLE_CHECKSUM;
            r_cur_idle <= 1'b1;
            r_phase    <= PH_PRE;
            r_bit_cnt  <= '0;
            r_byte_idx <= '0;
        end else begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_fill     <= n_fill;
            r_cur      <= n_cur;
            r_cur_csum <= n_cur_csum;
            r_cur_idle <= n_cur_idle;
            r_phase    <= n_phase;
            r_bit_cnt  <= n_bit_cnt;
            r_byte_idx <= n_byte_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preamble <= PREAMBLE_RESET;
        end else if (i_cfg_we) begin
            r_preamble <= i_cfg_data;
        end
    end

    // Result register: load on a request, drop once the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line_bit    <= n_line_bit;
            r_packet_done <= n_packet_done;
            r_enqueue_ok  <= n_enqueue_ok;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_line_bit    = r_line_bit;
    assign o_packet_done = r_packet_done;
    assign o_enqueue_ok  = r_enqueue_ok;

endmodule
